/* hdl/obpp_pkg.sv */
// Shared types and constants for the oriented box point push-out core.
// No dependencies.
package obpp_pkg;

    localparam int POS_W      = 25;
    localparam int COEF_W     = 16;
    localparam int BND_W      = 16;
    localparam int RAD_W      = 12;
    localparam int DIFF_W     = POS_W + 1;
    localparam int PROD_W     = COEF_W + DIFF_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int EDGE_W     = BND_W + 1;
    localparam int BPROD_W    = 2 * BND_W;
    localparam int BSUM_W     = BPROD_W + 1;
    localparam int NUM_STAGES = 7;

    typedef logic [NUM_STAGES-1:0] stage_en_t;

    typedef struct packed {
        logic signed [POS_W-1:0]  obj_x;
        logic signed [POS_W-1:0]  obj_z;
        logic signed [POS_W-1:0]  pt_x;
        logic signed [POS_W-1:0]  pt_z;
        logic signed [COEF_W-1:0] cos_val;
        logic signed [COEF_W-1:0] sin_val;
    } ctx_t;

    typedef struct packed {
        logic signed [BND_W-1:0] min_x;
        logic signed [BND_W-1:0] max_x;
        logic signed [BND_W-1:0] min_z;
        logic signed [BND_W-1:0] max_z;
    } bounds_t;

endpackage

/* hdl/obpp_rotate_in.sv */
// Stages 1-3: offset, grown bounds, rotation into the box frame.
// Depends on obpp_pkg.
module obpp_rotate_in
    import obpp_pkg::*;
#(
    parameter int ROTATION_SHIFT = 14
) (
    input  logic                              aclk,
    input  logic [2:0]                        en,
    input  ctx_t                              ctx_in,
    input  bounds_t                           bnd_in,
    input  logic [RAD_W-1:0]                  radius,
    output ctx_t                              ctx_out,
    output bounds_t                           bnd_out,
    output logic signed [SUM_W-ROTATION_SHIFT-1:0] rx,
    output logic signed [SUM_W-ROTATION_SHIFT-1:0] rz
);

    ctx_t    ctx1_reg, ctx2_reg, ctx3_reg;
    bounds_t bnd1_reg, bnd2_reg, bnd3_reg;
    bounds_t bnd1_next;
    logic signed [DIFF_W-1:0] dx_reg, dz_reg, dx_next, dz_next;
    logic signed [PROD_W-1:0] cdx_reg, sdz_reg, sdx_reg, cdz_reg;
    logic signed [SUM_W-1:0]  sum_x_next, sum_z_next;
    logic signed [SUM_W-ROTATION_SHIFT-1:0] rx_reg, rz_reg;
    logic [BND_W-1:0] rad_ext;

    assign rad_ext = {{(BND_W-RAD_W){1'b0}}, radius};

    always_comb begin
        dx_next         = DIFF_W'(ctx_in.pt_x) - DIFF_W'(ctx_in.obj_x);
        dz_next         = DIFF_W'(ctx_in.pt_z) - DIFF_W'(ctx_in.obj_z);
        bnd1_next.min_x = bnd_in.min_x - $signed(rad_ext);
        bnd1_next.max_x = bnd_in.max_x + $signed(rad_ext);
        bnd1_next.min_z = bnd_in.min_z - $signed(rad_ext);
        bnd1_next.max_z = bnd_in.max_z + $signed(rad_ext);
    end

    always_comb begin
        sum_x_next = SUM_W'(cdx_reg) - SUM_W'(sdz_reg);
        sum_z_next = SUM_W'(sdx_reg) + SUM_W'(cdz_reg);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            ctx1_reg <= ctx_in;
            bnd1_reg <= bnd1_next;
            dx_reg   <= dx_next;
            dz_reg   <= dz_next;
        end
        if (en[1]) begin
            ctx2_reg <= ctx1_reg;
            bnd2_reg <= bnd1_reg;
            cdx_reg  <= ctx1_reg.cos_val * dx_reg;
            sdz_reg  <= ctx1_reg.sin_val * dz_reg;
            sdx_reg  <= ctx1_reg.sin_val * dx_reg;
            cdz_reg  <= ctx1_reg.cos_val * dz_reg;
        end
        if (en[2]) begin
            ctx3_reg <= ctx2_reg;
            bnd3_reg <= bnd2_reg;
            // arithmetic shift right: drop the low bits
            rx_reg   <= sum_x_next[SUM_W-1:ROTATION_SHIFT];
            rz_reg   <= sum_z_next[SUM_W-1:ROTATION_SHIFT];
        end
    end

    assign ctx_out = ctx3_reg;
    assign bnd_out = bnd3_reg;
    assign rx      = rx_reg;
    assign rz      = rz_reg;

endmodule

/* hdl/obpp_push.sv */
// Stages 4-5: containment test, edge distances and nearest-edge push.
// Depends on obpp_pkg.
module obpp_push
    import obpp_pkg::*;
#(
    parameter int ROTATION_SHIFT = 14
) (
    input  logic                                  aclk,
    input  logic [1:0]                            en,
    input  ctx_t                                  ctx_in,
    input  bounds_t                               bnd_in,
    input  logic signed [SUM_W-ROTATION_SHIFT-1:0] rx,
    input  logic signed [SUM_W-ROTATION_SHIFT-1:0] rz,
    output ctx_t                                  ctx_out,
    output logic                                  hit,
    output logic signed [BND_W-1:0]               px_loc,
    output logic signed [BND_W-1:0]               pz_loc
);

    localparam int RW = SUM_W - ROTATION_SHIFT;

    logic signed [RW-1:0] min_x_e, max_x_e, min_z_e, max_z_e;
    logic signed [BND_W-1:0] rx16, rz16;
    logic signed [EDGE_W-1:0] l_c, r_c, t_c, b_c;
    logic inside_next;

    ctx_t    ctx4_reg, ctx5_reg;
    bounds_t bnd4_reg;
    logic inside4_reg, inside5_reg;
    logic [EDGE_W-1:0] l_reg, r_reg, t_reg, b_reg;
    logic signed [BND_W-1:0] rx4_reg, rz4_reg;
    logic signed [BND_W-1:0] px_next, pz_next, px5_reg, pz5_reg;

    always_comb begin
        min_x_e     = RW'(bnd_in.min_x);
        max_x_e     = RW'(bnd_in.max_x);
        min_z_e     = RW'(bnd_in.min_z);
        max_z_e     = RW'(bnd_in.max_z);
        inside_next = (rx >= min_x_e) && (rx <= max_x_e) &&
                      (rz >= min_z_e) && (rz <= max_z_e);
        rx16        = rx[BND_W-1:0];
        rz16        = rz[BND_W-1:0];
        l_c         = EDGE_W'(rx16) - EDGE_W'(bnd_in.min_x);
        r_c         = EDGE_W'(bnd_in.max_x) - EDGE_W'(rx16);
        t_c         = EDGE_W'(bnd_in.max_z) - EDGE_W'(rz16);
        b_c         = EDGE_W'(rz16) - EDGE_W'(bnd_in.min_z);
    end

    // distances are nonnegative for an inside point; ties: left, right, far, near
    always_comb begin
        px_next = rx4_reg;
        pz_next = rz4_reg;
        if (l_reg <= r_reg && l_reg <= t_reg && l_reg <= b_reg) begin
            px_next = bnd4_reg.min_x;
        end else if (r_reg <= l_reg && r_reg <= t_reg && r_reg <= b_reg) begin
            px_next = bnd4_reg.max_x;
        end else if (t_reg <= l_reg && t_reg <= r_reg && t_reg <= b_reg) begin
            pz_next = bnd4_reg.max_z;
        end else begin
            pz_next = bnd4_reg.min_z;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            ctx4_reg    <= ctx_in;
            bnd4_reg    <= bnd_in;
            inside4_reg <= inside_next;
            l_reg       <= l_c;
            r_reg       <= r_c;
            t_reg       <= t_c;
            b_reg       <= b_c;
            rx4_reg     <= rx16;
            rz4_reg     <= rz16;
        end
        if (en[1]) begin
            ctx5_reg    <= ctx4_reg;
            inside5_reg <= inside4_reg;
            px5_reg     <= px_next;
            pz5_reg     <= pz_next;
        end
    end

    assign ctx_out = ctx5_reg;
    assign hit     = inside5_reg;
    assign px_loc  = px5_reg;
    assign pz_loc  = pz5_reg;

endmodule

/* hdl/obpp_rotate_out.sv */
// Stages 6-7: rotation back to world frame and the output register.
// Depends on obpp_pkg.
module obpp_rotate_out
    import obpp_pkg::*;
#(
    parameter int ROTATION_SHIFT = 14
) (
    input  logic                      aclk,
    input  logic [1:0]                en,
    input  ctx_t                      ctx_in,
    input  logic                      hit,
    input  logic signed [BND_W-1:0]   px_loc,
    input  logic signed [BND_W-1:0]   pz_loc,
    output logic signed [POS_W-1:0]   new_x,
    output logic signed [POS_W-1:0]   new_z,
    output logic                      pushed
);

    localparam int AW = BSUM_W - ROTATION_SHIFT;

    ctx_t ctx6_reg;
    logic inside6_reg;
    logic signed [BPROD_W-1:0] zs_reg, xc_reg, zc_reg, xs_reg;
    logic signed [BSUM_W-1:0]  sum_x, sum_z;
    logic signed [AW-1:0]      ax, az;
    logic signed [POS_W-1:0]   new_x_next, new_z_next;
    logic signed [POS_W-1:0]   new_x_reg, new_z_reg;
    logic                      pushed_reg;

    always_comb begin
        sum_x = BSUM_W'(zs_reg) + BSUM_W'(xc_reg);
        sum_z = BSUM_W'(zc_reg) - BSUM_W'(xs_reg);
        ax    = sum_x[BSUM_W-1:ROTATION_SHIFT];
        az    = sum_z[BSUM_W-1:ROTATION_SHIFT];
        if (inside6_reg) begin
            new_x_next = ctx6_reg.obj_x + POS_W'(ax);
            new_z_next = ctx6_reg.obj_z + POS_W'(az);
        end else begin
            new_x_next = ctx6_reg.pt_x;
            new_z_next = ctx6_reg.pt_z;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            ctx6_reg    <= ctx_in;
            inside6_reg <= hit;
            zs_reg      <= pz_loc * ctx_in.sin_val;
            xc_reg      <= px_loc * ctx_in.cos_val;
            zc_reg      <= pz_loc * ctx_in.cos_val;
            xs_reg      <= px_loc * ctx_in.sin_val;
        end
        if (en[1]) begin
            new_x_reg  <= new_x_next;
            new_z_reg  <= new_z_next;
            pushed_reg <= inside6_reg;
        end
    end

    assign new_x  = new_x_reg;
    assign new_z  = new_z_reg;
    assign pushed = pushed_reg;

endmodule

/* hdl/oriented_box_point_pushout_core.sv */
// Top level of the oriented box point push-out core.
// Depends on obpp_pkg, obpp_rotate_in, obpp_push, obpp_rotate_out.
//
// Takes one query per cycle while the output side is not stalled and returns one
// result per query, in order. The pipeline has seven register stages: offset and
// bound growth, four rotation multipliers, product sums, containment test, edge
// push, four back-rotation multipliers, and the output register. Each stage has
// its own valid bit and advances when it is empty or the stage after it advances,
// so bubbles are squeezed out and new queries are taken while a result waits.
// push_radius is written through the cfg channel, which is always ready; write
// it only while the pipeline is empty.
module oriented_box_point_pushout_core
    import obpp_pkg::*;
#(
    parameter int ROTATION_SHIFT = 14
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [RAD_W-1:0]         cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [POS_W-1:0]  s_obj_x,
    input  logic signed [POS_W-1:0]  s_obj_z,
    input  logic signed [POS_W-1:0]  s_pt_x,
    input  logic signed [POS_W-1:0]  s_pt_z,
    input  logic signed [COEF_W-1:0] s_cos_val,
    input  logic signed [COEF_W-1:0] s_sin_val,
    input  logic signed [BND_W-1:0]  s_box_min_x,
    input  logic signed [BND_W-1:0]  s_box_max_x,
    input  logic signed [BND_W-1:0]  s_box_min_z,
    input  logic signed [BND_W-1:0]  s_box_max_z,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [POS_W-1:0]  m_new_x,
    output logic signed [POS_W-1:0]  m_new_z,
    output logic                     m_pushed
);

    localparam int RW = SUM_W - ROTATION_SHIFT;

    logic [RAD_W-1:0]  push_radius_reg;
    stage_en_t         valid_reg, valid_next;
    stage_en_t         adv;

    ctx_t    ctx_in, ctx3, ctx5;
    bounds_t bnd_in, bnd3;
    logic signed [RW-1:0]    rx3, rz3;
    logic                    inside5;
    logic signed [BND_W-1:0] px5, pz5;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            push_radius_reg <= '0;
        end else if (cfg_valid) begin
            push_radius_reg <= cfg_data;
        end
    end

    always_comb begin
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (adv[0]) begin
            valid_next[0] = s_valid;
        end
        for (int i = 1; i < NUM_STAGES; i++) begin
            if (adv[i]) begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = adv[0];
    assign m_valid = valid_reg[NUM_STAGES-1];

    always_comb begin
        ctx_in.obj_x   = s_obj_x;
        ctx_in.obj_z   = s_obj_z;
        ctx_in.pt_x    = s_pt_x;
        ctx_in.pt_z    = s_pt_z;
        ctx_in.cos_val = s_cos_val;
        ctx_in.sin_val = s_sin_val;
        bnd_in.min_x   = s_box_min_x;
        bnd_in.max_x   = s_box_max_x;
        bnd_in.min_z   = s_box_min_z;
        bnd_in.max_z   = s_box_max_z;
    end

    obpp_rotate_in #(
        .ROTATION_SHIFT (ROTATION_SHIFT)
    ) u_rotate_in (
        .aclk    (aclk),
        .en      (adv[2:0]),
        .ctx_in  (ctx_in),
        .bnd_in  (bnd_in),
        .radius  (push_radius_reg),
        .ctx_out (ctx3),
        .bnd_out (bnd3),
        .rx      (rx3),
        .rz      (rz3)
    );

    obpp_push #(
        .ROTATION_SHIFT (ROTATION_SHIFT)
    ) u_push (
        .aclk    (aclk),
        .en      (adv[4:3]),
        .ctx_in  (ctx3),
        .bnd_in  (bnd3),
        .rx      (rx3),
        .rz      (rz3),
        .ctx_out (ctx5),
        .hit     (inside5),
        .px_loc  (px5),
        .pz_loc  (pz5)
    );

    obpp_rotate_out #(
        .ROTATION_SHIFT (ROTATION_SHIFT)
    ) u_rotate_out (
        .aclk   (aclk),
        .en     (adv[6:5]),
        .ctx_in (ctx5),
        .hit    (inside5),
        .px_loc (px5),
        .pz_loc (pz5),
        .new_x  (m_new_x),
        .new_z  (m_new_z),
        .pushed (m_pushed)
    );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for oriented_box_point_pushout_core: a directed table, then random
// collision queries, checked against typed-in results or a behavioral push-out predictor kept in this file.
// Depends on obpp_pkg and the oriented_box_point_pushout_core RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import obpp_pkg::*;

    localparam int ROT_SHIFT    = 14;
    localparam int UNIT         = 1 << ROT_SHIFT;
    localparam int RAD_MAX      = (1 << RAD_W) - 1;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 6;
    localparam int NUM_PHASES   = 6;
    localparam int PHASE_ITEMS  = 200;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4 * NUM_STAGES;
    localparam int MAX_PRINTS   = 100;
    localparam bit TYPED        = 1'b1;
    localparam bit MODEL        = 1'b0;

    typedef struct packed {
        ctx_t    ctx;
        bounds_t box;
    } query_t;

    typedef struct packed {
        logic signed [POS_W-1:0] new_x;
        logic signed [POS_W-1:0] new_z;
        logic                    pushed;
    } pushout_t;

    // radius, object, point, heading, bounds, then a typed-in result where chk is TYPED
    typedef struct packed {
        int rad;
        int ox;
        int oz;
        int px;
        int pz;
        int cs;
        int sn;
        int mnx;
        int mxx;
        int mnz;
        int mxz;
        bit chk;
        int ex;
        int ez;
        bit ep;
    } dir_row_t;

    localparam int DIR_N = 24;
    localparam dir_row_t DIR_TAB [DIR_N] = '{
        // ties: all four equal, right over far, far alone, near alone, left over near
        '{0, 0, 0, 0, 0, UNIT, 0, -100, 100, -100, 100, TYPED, -100, 0, 1},
        '{0, 0, 0, 50, 50, UNIT, 0, -100, 100, -100, 100, TYPED, 100, 50, 1},
        '{0, 0, 0, 0, 50, UNIT, 0, -100, 100, -100, 100, TYPED, 0, 100, 1},
        '{0, 0, 0, 0, -50, UNIT, 0, -100, 100, -100, 100, TYPED, 0, -100, 1},
        '{0, 0, 0, -50, -50, UNIT, 0, -100, 100, -100, 100, TYPED, -100, -50, 1},
        // far over near
        '{0, 0, 0, 0, 0, UNIT, 0, -1000, 1000, -100, 100, TYPED, 0, 100, 1},
        // on the edge, then just outside, then a push from an offset object
        '{0, 0, 0, 100, 0, UNIT, 0, -100, 100, -100, 100, TYPED, 100, 0, 1},
        '{0, 0, 0, 101, 0, UNIT, 0, -100, 100, -100, 100, TYPED, 101, 0, 0},
        '{0, 0, 0, 0, -101, UNIT, 0, -100, 100, -100, 100, TYPED, 0, -101, 0},
        '{0, 1000, -2000, 1010, -1905, UNIT, 0, -100, 100, -100, 100, TYPED, 1010, -1900, 1},
        // rotated headings and coefficients beyond the unit range
        '{0, 0, 0, 30, -70, 0, UNIT, -100, 100, -100, 100, MODEL, 0, 0, 0},
        '{0, 0, 0, 40, 10, 11585, 11585, -100, 100, -100, 100, MODEL, 0, 0, 0},
        '{0, 500, 500, 480, 530, -UNIT, 0, -50, 80, -60, 40, MODEL, 0, 0, 0},
        '{0, 0, 0, 5, 3, -32768, 32767, -32768, 32767, -32768, 32767, MODEL, 0, 0, 0},
        '{0, 0, 0, -3, 7, 16383, 1, -10, 10, -10, 10, MODEL, 0, 0, 0},
        // field extremes
        '{0, -16777216, -16777216, -16777216, -16777216, -32768, -32768,
          -32768, -32768, -32768, -32768, TYPED, -16777216, -16777216, 0},
        '{0, 16777215, 16777215, 16777215, 16777215, 32767, 32767,
          32767, 32767, 32767, 32767, TYPED, 16777215, 16777215, 0},
        '{0, -16777216, 16777215, 16777215, -16777216, UNIT, 0,
          -32768, 32767, -32768, 32767, MODEL, 0, 0, 0},
        // result wraps past the position range
        '{0, 16777200, 0, 16777210, 0, UNIT, 0, -100, 100, -100, 100, MODEL, 0, 0, 0},
        '{0, -16777200, 0, -16777210, 0, UNIT, 0, -100, 100, -100, 100, MODEL, 0, 0, 0},
        // widest margin, bounds that wrap into an inverted box, grown corner
        '{RAD_MAX, 0, 0, 4000, 0, UNIT, 0, -100, 100, -100, 100, MODEL, 0, 0, 0},
        '{RAD_MAX, 0, 0, 0, 0, UNIT, 0, -100, 32767, -100, 100, TYPED, 0, 0, 0},
        '{RAD_MAX, 0, 0, 0, 0, UNIT, 0, -100, 100, -32768, 100, TYPED, 0, 0, 0},
        '{RAD_MAX, 0, 0, -4195, 4195, UNIT, 0, -100, 100, -100, 100, MODEL, 0, 0, 0}
    };

    logic                     aclk        = 1'b0;
    logic                     aresetn     = 1'b0;
    logic                     cfg_valid   = 1'b0;
    logic                     cfg_ready;
    logic [RAD_W-1:0]         cfg_data    = '0;
    logic                     s_valid     = 1'b0;
    logic                     s_ready;
    logic signed [POS_W-1:0]  s_obj_x     = '0;
    logic signed [POS_W-1:0]  s_obj_z     = '0;
    logic signed [POS_W-1:0]  s_pt_x      = '0;
    logic signed [POS_W-1:0]  s_pt_z      = '0;
    logic signed [COEF_W-1:0] s_cos_val   = '0;
    logic signed [COEF_W-1:0] s_sin_val   = '0;
    logic signed [BND_W-1:0]  s_box_min_x = '0;
    logic signed [BND_W-1:0]  s_box_max_x = '0;
    logic signed [BND_W-1:0]  s_box_min_z = '0;
    logic signed [BND_W-1:0]  s_box_max_z = '0;
    logic                     m_valid;
    logic                     m_ready     = 1'b0;
    logic signed [POS_W-1:0]  m_new_x;
    logic signed [POS_W-1:0]  m_new_z;
    logic                     m_pushed;

    logic [RAD_W-1:0] radius         = '0;
    bit               gaps_on        = 1'b1;
    int               mismatch_count = 0;
    pushout_t         pending_pushouts [$];

    oriented_box_point_pushout_core #(
        .ROTATION_SHIFT(ROT_SHIFT)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_obj_x    (s_obj_x),
        .s_obj_z    (s_obj_z),
        .s_pt_x     (s_pt_x),
        .s_pt_z     (s_pt_z),
        .s_cos_val  (s_cos_val),
        .s_sin_val  (s_sin_val),
        .s_box_min_x(s_box_min_x),
        .s_box_max_x(s_box_max_x),
        .s_box_min_z(s_box_min_z),
        .s_box_max_z(s_box_max_z),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_new_x    (m_new_x),
        .m_new_z    (m_new_z),
        .m_pushed   (m_pushed)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic pushout_t predict_pushout(query_t q, logic [RAD_W-1:0] rad);
        longint c, s, rl, dx, dz, rx, rz, mnx, mxx, mnz, mxz, l, r, t, b;
        logic signed [BND_W-1:0] gmnx, gmxx, gmnz, gmxz;
        pushout_t res;
        c  = q.ctx.cos_val;
        s  = q.ctx.sin_val;
        rl = longint'(rad);
        gmnx = BND_W'(longint'(q.box.min_x) - rl);
        gmxx = BND_W'(longint'(q.box.max_x) + rl);
        gmnz = BND_W'(longint'(q.box.min_z) - rl);
        gmxz = BND_W'(longint'(q.box.max_z) + rl);
        mnx = gmnx;
        mxx = gmxx;
        mnz = gmnz;
        mxz = gmxz;
        dx = longint'(q.ctx.pt_x) - longint'(q.ctx.obj_x);
        dz = longint'(q.ctx.pt_z) - longint'(q.ctx.obj_z);
        rx = (c * dx - s * dz) >>> ROT_SHIFT;
        rz = (s * dx + c * dz) >>> ROT_SHIFT;
        res.new_x  = q.ctx.pt_x;
        res.new_z  = q.ctx.pt_z;
        res.pushed = 1'b0;
        if (rx >= mnx && rx <= mxx && rz >= mnz && rz <= mxz) begin
            l = rx - mnx;
            r = mxx - rx;
            t = mxz - rz;
            b = rz - mnz;
            if (l <= r && l <= t && l <= b) begin
                rx = mnx;
            end else if (r <= l && r <= t && r <= b) begin
                rx = mxx;
            end else if (t <= l && t <= r && t <= b) begin
                rz = mxz;
            end else begin
                rz = mnz;
            end
            res.new_x  = POS_W'(longint'(q.ctx.obj_x) + ((rz * s + rx * c) >>> ROT_SHIFT));
            res.new_z  = POS_W'(longint'(q.ctx.obj_z) + ((rz * c - rx * s) >>> ROT_SHIFT));
            res.pushed = 1'b1;
        end
        return res;
    endfunction

    // Mostly points placed near the grown box of a chosen heading, some pure noise.
    function automatic query_t random_query(logic [RAD_W-1:0] rad);
        query_t q;
        longint c, s, rl, mnx, mxx, mnz, mxz, lx, lz, dx, dz;
        q.ctx.obj_x   = POS_W'($urandom());
        q.ctx.obj_z   = POS_W'($urandom());
        q.ctx.pt_x    = POS_W'($urandom());
        q.ctx.pt_z    = POS_W'($urandom());
        q.ctx.cos_val = COEF_W'($urandom());
        q.ctx.sin_val = COEF_W'($urandom());
        q.box.min_x   = BND_W'($urandom());
        q.box.max_x   = BND_W'($urandom());
        q.box.min_z   = BND_W'($urandom());
        q.box.max_z   = BND_W'($urandom());
        if ($urandom_range(99) < 15) begin
            return q;
        end
        case ($urandom_range(5))
            0: begin c = UNIT;  s = 0;     end
            1: begin c = 0;     s = UNIT;  end
            2: begin c = 11585; s = 11585; end
            3: begin c = 14189; s = 8192;  end
            4: begin c = 8192;  s = 14189; end
            default: begin
                c = longint'($urandom_range(2 * UNIT)) - UNIT;
                s = longint'($urandom_range(2 * UNIT)) - UNIT;
            end
        endcase
        if ($urandom_range(1) == 1) c = -c;
        if ($urandom_range(1) == 1) s = -s;
        mnx = longint'($urandom_range(4000)) - 2000 - longint'($urandom_range(3000));
        mxx = mnx + longint'($urandom_range(6000));
        mnz = longint'($urandom_range(4000)) - 2000 - longint'($urandom_range(3000));
        mxz = mnz + longint'($urandom_range(6000));
        if ($urandom_range(9) == 0) begin
            mnx = -32768 + longint'($urandom_range(64));
            mxx = 32767 - longint'($urandom_range(64));
        end
        if ($urandom_range(9) == 0) begin
            mnz = -32768 + longint'($urandom_range(64));
            mxz = 32767 - longint'($urandom_range(64));
        end
        rl = longint'(rad);
        lx = mnx - rl - 16 + longint'($urandom_range(32'(mxx - mnx + 2 * rl + 32)));
        lz = mnz - rl - 16 + longint'($urandom_range(32'(mxz - mnz + 2 * rl + 32)));
        if ($urandom_range(4) == 0) lx = (mnx + mxx) >>> 1;
        if ($urandom_range(4) == 0) lz = (mnz + mxz) >>> 1;
        dx = (lz * s + lx * c) >>> ROT_SHIFT;
        dz = (lz * c - lx * s) >>> ROT_SHIFT;
        q.ctx.cos_val = COEF_W'(c);
        q.ctx.sin_val = COEF_W'(s);
        q.box.min_x   = BND_W'(mnx);
        q.box.max_x   = BND_W'(mxx);
        q.box.min_z   = BND_W'(mnz);
        q.box.max_z   = BND_W'(mxz);
        q.ctx.pt_x    = POS_W'(longint'(q.ctx.obj_x) + dx);
        q.ctx.pt_z    = POS_W'(longint'(q.ctx.obj_z) + dz);
        return q;
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTS) begin
            $display("%0t tb_top: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_query(input query_t q, input pushout_t want);
        while (gaps_on && $urandom_range(99) < 32) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_obj_x     = q.ctx.obj_x;
        s_obj_z     = q.ctx.obj_z;
        s_pt_x      = q.ctx.pt_x;
        s_pt_z      = q.ctx.pt_z;
        s_cos_val   = q.ctx.cos_val;
        s_sin_val   = q.ctx.sin_val;
        s_box_min_x = q.box.min_x;
        s_box_max_x = q.box.max_x;
        s_box_min_z = q.box.min_z;
        s_box_max_z = q.box.max_z;
        s_valid     = 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_pushouts.push_back(want);
        @(negedge aclk);
    endtask

    // Drains the pipeline, then writes the radius; also sets idling for the next phase.
    task automatic write_radius(input logic [RAD_W-1:0] value, input bit gaps);
        s_valid = 1'b0;
        while (pending_pushouts.size() != 0) @(posedge aclk);
        gaps_on = gaps;
        @(negedge aclk);
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        radius = value;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    always @(negedge aclk) begin
        m_ready = !gaps_on || ($urandom_range(99) >= 32);
    end

    always @(posedge aclk) begin
        pushout_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pushouts.size() == 0) begin
                flag_mismatch($sformatf("result transfer with no query outstanding: x %0d z %0d",
                                        m_new_x, m_new_z));
            end else begin
                want = pending_pushouts.pop_front();
                if (m_new_x !== want.new_x)
                    flag_mismatch($sformatf("new_x got %0d want %0d", m_new_x, want.new_x));
                if (m_new_z !== want.new_z)
                    flag_mismatch($sformatf("new_z got %0d want %0d", m_new_z, want.new_z));
                if (m_pushed !== want.pushed)
                    flag_mismatch($sformatf("pushed got %b want %b", m_pushed, want.pushed));
            end
        end
    end

    initial begin : watchdog
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                stall = 0;
            else
                stall++;
        end
        $display("FAIL oriented_box_point_pushout_core");
        $finish;
    end

    initial begin : stimulus
        query_t           q;
        pushout_t         want;
        dir_row_t         row;
        logic [RAD_W-1:0] next_rad;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < DIR_N; i++) begin
            row = DIR_TAB[i];
            if (row.rad != int'(radius)) write_radius(RAD_W'(row.rad), 1'b1);
            q.ctx.obj_x   = POS_W'(row.ox);
            q.ctx.obj_z   = POS_W'(row.oz);
            q.ctx.pt_x    = POS_W'(row.px);
            q.ctx.pt_z    = POS_W'(row.pz);
            q.ctx.cos_val = COEF_W'(row.cs);
            q.ctx.sin_val = COEF_W'(row.sn);
            q.box.min_x   = BND_W'(row.mnx);
            q.box.max_x   = BND_W'(row.mxx);
            q.box.min_z   = BND_W'(row.mnz);
            q.box.max_z   = BND_W'(row.mxz);
            if (row.chk == TYPED) begin
                want.new_x  = POS_W'(row.ex);
                want.new_z  = POS_W'(row.ez);
                want.pushed = row.ep;
            end else begin
                want = predict_pushout(q, radius);
            end
            send_query(q, want);
        end

        // phase 2 runs with no idling on either side
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       next_rad = '0;
                1, 5:    next_rad = RAD_W'(RAD_MAX);
                3:       next_rad = RAD_W'(1);
                default: next_rad = RAD_W'($urandom_range(RAD_MAX));
            endcase
            write_radius(next_rad, p != 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                q = random_query(radius);
                send_query(q, predict_pushout(q, radius));
            end
        end
        s_valid = 1'b0;

        while (pending_pushouts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS oriented_box_point_pushout_core");
        end else begin
            $display("FAIL oriented_box_point_pushout_core");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/obpp_pkg.sv
hdl/obpp_rotate_in.sv
hdl/obpp_push.sv
hdl/obpp_rotate_out.sv
hdl/oriented_box_point_pushout_core.sv
tb/tb_top.sv
